// File: src/seven_bit_frame_decoder_macros.svh
// Assertion macros shared by the frame decoder RTL.
`ifndef SEVEN_BIT_FRAME_DECODER_MACROS_SVH
`define SEVEN_BIT_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define SBFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define SBFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sbfd_pkg.sv
// Package: codes, widths and state types of the seven-bit frame decoder.
`default_nettype none

package sbfd_pkg;

  localparam int unsigned MAX_CODED_BYTES_DEF = 1008;
  localparam int unsigned CNT_W = 10;

  localparam logic [7:0] FRAME_START = 8'hFE;
  localparam logic [7:0] FRAME_END   = 8'hFF;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_BAD_SUM  = 3'd1;
  localparam logic [2:0] STAT_SHORT    = 3'd2;
  localparam logic [2:0] STAT_OVERFLOW = 3'd3;
  localparam logic [2:0] STAT_ABORT    = 3'd4;

  localparam logic [2:0] PHASE_LAST = 3'd7;

  typedef struct packed {
    logic             in_frame;
    logic [2:0]       bit_phase;
    logic [7:0]       prev_coded;
    logic [7:0]       held0;
    logic [7:0]       held1;
    logic [1:0]       held_count;
    logic [7:0]       xor_sum;
    logic [CNT_W-1:0] coded_count;
    logic [CNT_W-1:0] emitted_count;
    logic             overflowed;
  } sbfd_state_t;

  typedef struct packed {
    logic             valid;
    logic             is_end;
    logic [7:0]       data_byte;
    logic [2:0]       frame_status;
    logic [CNT_W-1:0] payload_count;
  } sbfd_result_t;

endpackage

`default_nettype wire

// File: src/sbfd_step.sv
// Next-state and result logic for one received link byte.
`default_nettype none

module sbfd_step #(
  parameter int unsigned MAX_CODED_BYTES = sbfd_pkg::MAX_CODED_BYTES_DEF
) (
  input  wire logic [7:0]           rx_byte,
  input  wire sbfd_pkg::sbfd_state_t cur,
  output sbfd_pkg::sbfd_state_t     nxt,
  output sbfd_pkg::sbfd_result_t    res
);
  import sbfd_pkg::*;

  localparam logic [CNT_W-1:0] CODED_LIMIT = CNT_W'(MAX_CODED_BYTES);

  logic [7:0] dec_byte;
  logic [2:0] k;

  assign k        = cur.bit_phase;
  assign dec_byte = 8'(cur.prev_coded << k) | 8'(rx_byte >> (PHASE_LAST - k));

  always_comb begin
    nxt = cur;
    res = '0;
    if (rx_byte == FRAME_START) begin
      if (cur.in_frame) begin
        res.valid         = 1'b1;
        res.is_end        = 1'b1;
        res.frame_status  = STAT_ABORT;
        res.payload_count = cur.emitted_count;
      end
      nxt          = '0;
      nxt.in_frame = 1'b1;
    end else if (!cur.in_frame) begin
      nxt = cur;
    end else if (rx_byte == FRAME_END) begin
      res.valid         = 1'b1;
      res.is_end        = 1'b1;
      res.payload_count = cur.emitted_count;
      if (cur.overflowed) begin
        res.frame_status = STAT_OVERFLOW;
      end else if (cur.held_count < 2'd2 || cur.emitted_count == '0) begin
        res.frame_status = STAT_SHORT;
      end else if (cur.held0 != 8'h00 || cur.held1 != cur.xor_sum) begin
        res.frame_status = STAT_BAD_SUM;
      end else begin
        res.frame_status = STAT_OK;
      end
      nxt.in_frame = 1'b0;
    end else if (cur.overflowed) begin
      nxt = cur;
    end else if (cur.coded_count >= CODED_LIMIT) begin
      nxt.overflowed = 1'b1;
    end else begin
      nxt.coded_count = cur.coded_count + 1'b1;
      nxt.prev_coded  = rx_byte;
      if (cur.bit_phase == 3'd0) begin
        nxt.bit_phase = 3'd1;
      end else begin
        nxt.bit_phase = (k == PHASE_LAST) ? 3'd0 : k + 3'd1;
        if (cur.held_count == 2'd0) begin
          nxt.held0      = dec_byte;
          nxt.held_count = 2'd1;
        end else if (cur.held_count == 2'd1) begin
          nxt.held1      = dec_byte;
          nxt.held_count = 2'd2;
        end else begin
          // emit the oldest held byte, keep two in reserve for the checksum
          nxt.held0         = cur.held1;
          nxt.held1         = dec_byte;
          nxt.xor_sum       = cur.xor_sum ^ cur.held0;
          nxt.emitted_count = cur.emitted_count + 1'b1;
          res.valid         = 1'b1;
          res.data_byte     = cur.held0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/seven_bit_frame_decoder.sv
// Top level: seven-bit packed link frame decoder with registered in and out.
// A transferred byte is held in the input register; its result is then loaded into the result register.
// Throughput: one byte per cycle while out_ready does not stall; input and result registers pipeline it.
// in_ready drops only while a held result waits on out_ready and the input register is full.
// Reset (rst_n low, synchronous) empties both registers and clears all frame state.
`default_nettype none

module seven_bit_frame_decoder #(
  parameter int unsigned MAX_CODED_BYTES = sbfd_pkg::MAX_CODED_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_rx_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_is_end,
  output logic [7:0]                     out_data_byte,
  output logic [2:0]                     out_frame_status,
  output logic [sbfd_pkg::CNT_W-1:0]     out_payload_count
);
  import sbfd_pkg::*;

  `include "seven_bit_frame_decoder_macros.svh"

  // Input register stage.
  logic         in_vld_r;
  logic [7:0]   in_byte_r;

  // Frame state.
  sbfd_state_t  st_r;
  sbfd_state_t  st_nxt;
  sbfd_result_t res;

  // Result register.
  logic             out_vld_r;
  logic             out_is_end_r;
  logic [7:0]       out_data_r;
  logic [2:0]       out_status_r;
  logic [CNT_W-1:0] out_count_r;

  logic advance;

  // The pipe moves whenever the result slot is empty or being taken.
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || advance;

  sbfd_step #(
    .MAX_CODED_BYTES (MAX_CODED_BYTES)
  ) u_step (
    .rx_byte (in_byte_r),
    .cur     (st_r),
    .nxt     (st_nxt),
    .res     (res)
  );

  // Hold the byte until the step logic consumes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Advance frame state once per consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_vld_r && advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register: load on a new result, drop after the transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r && res.valid) begin
      out_is_end_r <= res.is_end;
      out_data_r   <= res.data_byte;
      out_status_r <= res.frame_status;
      out_count_r  <= res.payload_count;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_is_end        = out_is_end_r;
  assign out_data_byte     = out_data_r;
  assign out_frame_status  = out_status_r;
  assign out_payload_count = out_count_r;

  // A data result carries no status or count.
  `SBFD_ASSERT_NOW(a_data_clean, out_vld_r && !out_is_end_r,
    out_status_r == STAT_OK && out_count_r == '0, "data result with status bits")
  // Status codes stay in their defined range.
  `SBFD_ASSERT_NOW(a_status_range, out_vld_r && out_is_end_r,
    out_status_r <= STAT_ABORT, "undefined frame status")
  // Held-byte count never passes two.
  `SBFD_ASSERT_NOW(a_held_max, 1'b1, st_r.held_count <= 2'd2, "held count above two")
  // Emitting needs both checksum slots filled.
  `SBFD_ASSERT_NOW(a_emit_held, st_r.emitted_count != '0,
    st_r.held_count == 2'd2, "byte emitted without two held")
  // Overflow is flagged only at the coded-byte limit.
  `SBFD_ASSERT_NOW(a_ovf_limit, st_r.overflowed,
    st_r.coded_count == CNT_W'(MAX_CODED_BYTES), "overflow below limit")
  // A stalled result does not get overwritten.
  `SBFD_ASSERT_NEXT(a_no_overwrite, out_vld_r && !out_ready,
    out_vld_r && out_data_r == $past(out_data_r), "stalled result lost")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the seven-bit frame decoder: directed table, then random frames.
`default_nettype none

module testbench;
  import sbfd_pkg::*;

  // The coded-byte limit shared by the block and the predictor below.
  localparam int unsigned CODED_LIMIT = MAX_CODED_BYTES_DEF;

  // One decoded result as it shows up on the out_ channel.
  typedef struct packed {
    logic             is_end;
    logic [7:0]       data_byte;
    logic [2:0]       frame_status;
    logic [CNT_W-1:0] payload_count;
  } frame_result_t;

  // How a directed row is checked: against the predictor, against a typed-in value, or as giving no result.
  typedef enum logic [1:0] {ROW_MODEL, ROW_SILENT, ROW_BYTE, ROW_STATUS} row_kind_e;

  typedef struct packed {
    logic [7:0]       rx;
    row_kind_e        kind;
    logic [7:0]       data_byte;
    logic [2:0]       frame_status;
    logic [CNT_W-1:0] payload_count;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_rx_byte;
  logic out_valid;
  logic out_ready;
  logic out_is_end;
  logic [7:0] out_data_byte;
  logic [2:0] out_frame_status;
  logic [CNT_W-1:0] out_payload_count;

  seven_bit_frame_decoder #(
    .MAX_CODED_BYTES(CODED_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_is_end(out_is_end),
    .out_data_byte(out_data_byte),
    .out_frame_status(out_frame_status),
    .out_payload_count(out_payload_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle knobs, in percent of cycles; the main sequence changes them per phase.
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int in_idle_by_phase[5] = '{0, 87, 0, 33, 0};
  int out_stall_by_phase[5] = '{0, 0, 87, 33, 0};

  int n_errors = 0;
  int items_sent = 0;
  frame_result_t expected_results[$];

  // Long receiver hold-off, requested by the main sequence.
  event hold_off_start;
  logic out_hold;

  // ------------------------------------------------------------------
  // Frame decoder predictor: its own copy of the frame state.
  // ------------------------------------------------------------------
  logic             frame_open;
  logic [2:0]       group_phase;   // next shift amount; 0 means a group starts
  logic [7:0]       last_coded;
  logic [7:0]       held [2];      // two decoded bytes kept back as a possible checksum
  logic [1:0]       held_n;
  logic [7:0]       running_xor;
  logic [CNT_W-1:0] coded_n;
  logic [CNT_W-1:0] payload_n;
  logic             frame_overflow;

  function automatic void clear_frame_state();
    group_phase = 3'd0;
    last_coded = 8'h00;
    held[0] = 8'h00;
    held[1] = 8'h00;
    held_n = 2'd0;
    running_xor = 8'h00;
    coded_n = '0;
    payload_n = '0;
    frame_overflow = 1'b0;
  endfunction

  // Advance the predicted state by one link byte; return 1 when it yields a result.
  function automatic bit predict_frame_step(input logic [7:0] b, output frame_result_t r);
    logic       was_open;
    logic [2:0] k;
    logic [7:0] d;
    r = '0;
    if (b == FRAME_START) begin
      // A start inside a frame aborts it and reports what was emitted so far.
      was_open = frame_open;
      r.is_end = 1'b1;
      r.frame_status = STAT_ABORT;
      r.payload_count = payload_n;
      clear_frame_state();
      frame_open = 1'b1;
      return was_open;
    end
    if (!frame_open) return 1'b0;
    if (b == FRAME_END) begin
      frame_open = 1'b0;
      r.is_end = 1'b1;
      r.payload_count = payload_n;
      if (frame_overflow) r.frame_status = STAT_OVERFLOW;
      else if (held_n < 2'd2 || payload_n == '0) r.frame_status = STAT_SHORT;
      else if (held[0] != 8'h00 || held[1] != running_xor) r.frame_status = STAT_BAD_SUM;
      else r.frame_status = STAT_OK;
      return 1'b1;
    end
    // Drop everything once the frame has run past the coded-byte limit.
    if (frame_overflow) return 1'b0;
    if (coded_n >= CODED_LIMIT) begin
      frame_overflow = 1'b1;
      return 1'b0;
    end
    coded_n = coded_n + 1'b1;
    if (group_phase == 3'd0) begin
      last_coded = b;
      group_phase = 3'd1;
      return 1'b0;
    end
    k = group_phase;
    d = 8'((last_coded << k) | (b >> (3'd7 - k)));
    last_coded = b;
    group_phase = (k == PHASE_LAST) ? 3'd0 : k + 3'd1;
    if (held_n < 2'd2) begin
      held[held_n[0]] = d;
      held_n = held_n + 2'd1;
      return 1'b0;
    end
    // Emit the oldest held byte; the newest two stay back.
    r.data_byte = held[0];
    held[0] = held[1];
    held[1] = d;
    running_xor = running_xor ^ r.data_byte;
    payload_n = payload_n + 1'b1;
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------
  // Sender side
  // ------------------------------------------------------------------

  // Offer one byte, with random idle cycles first, and hold it until the transfer.
  task automatic transfer_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_link_byte(input logic [7:0] b);
    frame_result_t r;
    transfer_byte(b);
    if (predict_frame_step(b, r)) expected_results.push_back(r);
  endtask

  // Payload length: mostly short, now and then longer, zero included.
  function automatic int pick_payload_len();
    if ($urandom_range(9) == 0) return $urandom_range(60);
    return $urandom_range(12);
  endfunction

  // Build a frame with a valid checksum, pack it seven bits per coded byte and send it.
  // Corrupt flips one decoded bit and may set bit 7 of a coded byte; truncate leaves
  // the frame open so that the next start aborts it.
  task automatic send_frame(input int payload_len, input bit corrupt, input bit truncate);
    logic [7:0] plain[$];
    logic [7:0] coded[$];
    logic [7:0] sum;
    logic [7:0] c;
    int nbits;
    int ncoded;
    int p;
    int cut;
    sum = 8'h00;
    for (int i = 0; i < payload_len; i++) begin
      plain.push_back(8'($urandom));
      sum = sum ^ plain[i];
    end
    plain.push_back(8'h00);
    plain.push_back(sum);
    if (corrupt) plain[$urandom_range(plain.size() - 1)] ^= 8'(1 << $urandom_range(7));
    // Pack the decoded bits MSB first; pad the tail with random bits.
    nbits = 8 * plain.size();
    ncoded = (nbits + 6) / 7;
    for (int i = 0; i < ncoded; i++) begin
      c = 8'h00;
      for (int j = 0; j < 7; j++) begin
        p = 7 * i + j;
        c[6 - j] = (p < nbits) ? plain[p / 8][7 - p % 8] : 1'($urandom);
      end
      coded.push_back(c);
    end
    if (corrupt && $urandom_range(1)) coded[$urandom_range(ncoded - 1)][7] = 1'b1;
    cut = truncate ? $urandom_range(ncoded - 1) : ncoded;
    send_link_byte(FRAME_START);
    for (int i = 0; i < cut; i++) send_link_byte(coded[i]);
    if (!truncate) send_link_byte(FRAME_END);
    items_sent += cut + (truncate ? 1 : 2);
  endtask

  // Frame of random bytes over the whole range, starts and ends included.
  task automatic send_noise_frame();
    int n;
    n = $urandom_range(1, 20);
    send_link_byte(FRAME_START);
    for (int i = 0; i < n; i++) send_link_byte(8'($urandom));
    send_link_byte(FRAME_END);
    items_sent += n + 2;
  endtask

  // Frame with an exact number of coded bytes, to sit on or just past the limit.
  task automatic send_long_frame(input int n_coded);
    send_link_byte(FRAME_START);
    for (int i = 0; i < n_coded; i++) send_link_byte(8'($urandom_range(127)));
    send_link_byte(FRAME_END);
    items_sent += n_coded + 2;
  endtask

  // ------------------------------------------------------------------
  // Receiver side: random stalls, checking of every transfer
  // ------------------------------------------------------------------
  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      n_errors++;
      $display("%0t: result with none expected: expected nothing, actual end=%0b data=%0h %s",
               $time, out_is_end, out_data_byte,
               $sformatf("status=%0d count=%0d", out_frame_status, out_payload_count));
    end else begin
      want = expected_results.pop_front();
      check_field("is_end", CNT_W'(want.is_end), CNT_W'(out_is_end));
      check_field("data_byte", CNT_W'(want.data_byte), CNT_W'(out_data_byte));
      check_field("frame_status", CNT_W'(want.frame_status), CNT_W'(out_frame_status));
      check_field("payload_count", want.payload_count, out_payload_count);
    end
  endtask

  // Sample before the edge updates anything; drive ready for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    out_ready <= !out_hold && ($urandom_range(99) >= out_stall_pct);
  end

  // Hold off the receiver for a fixed stretch each time it is asked to.
  initial begin
    out_hold = 1'b0;
    forever begin
      @(hold_off_start);
      out_hold <= 1'b1;
      repeat (300) @(posedge clk);
      out_hold <= 1'b0;
    end
  end

  // Hard limit on the run.
  initial begin
    #5000000;
    $display("testbench failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    directed_row_t directed_rows [30];
    frame_result_t r;
    int pick;
    int phase_end;
    int wait_cycles;

    directed_rows = '{
      // End and coded byte while idle: ignored.
      '{8'hFF, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'h55, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      // Empty frame is too short.
      '{8'hFE, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'hFF, ROW_STATUS, 8'h00, STAT_SHORT, 10'd0},
      // Start right after start aborts the empty frame.
      '{8'hFE, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'hFE, ROW_STATUS, 8'h00, STAT_ABORT, 10'd0},
      // One zero payload byte with a zero checksum: ok.
      '{8'h00, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'h00, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'h00, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'h00, ROW_BYTE, 8'h00, STAT_OK, 10'd0},
      '{8'hFF, ROW_STATUS, 8'h00, STAT_OK, 10'd1},
      // Same frame with a wrong low checksum byte.
      '{8'hFE, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'h00, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'h00, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'h00, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'h7F, ROW_BYTE, 8'h00, STAT_OK, 10'd0},
      '{8'hFF, ROW_STATUS, 8'h00, STAT_BAD_SUM, 10'd1},
      // Extreme coded values, then an abort in mid-frame.
      '{8'hFE, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'hFD, ROW_MODEL, 8'h00, STAT_OK, 10'd0},
      '{8'h80, ROW_MODEL, 8'h00, STAT_OK, 10'd0},
      '{8'h01, ROW_MODEL, 8'h00, STAT_OK, 10'd0},
      '{8'h7F, ROW_MODEL, 8'h00, STAT_OK, 10'd0},
      '{8'h00, ROW_MODEL, 8'h00, STAT_OK, 10'd0},
      '{8'hFD, ROW_MODEL, 8'h00, STAT_OK, 10'd0},
      '{8'hFE, ROW_MODEL, 8'h00, STAT_OK, 10'd0},
      // Two decoded bytes and no payload: too short.
      '{8'h00, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'h00, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'h00, ROW_SILENT, 8'h00, STAT_OK, 10'd0},
      '{8'hFF, ROW_STATUS, 8'h00, STAT_SHORT, 10'd0},
      // End after end: ignored.
      '{8'hFF, ROW_SILENT, 8'h00, STAT_OK, 10'd0}
    };

    // Drive every input known from time zero; hold reset low first.
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    out_ready = 1'b0;
    frame_open = 1'b0;
    clear_frame_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: typed-in rows replace the predicted result, model rows use it, silent rows expect none.
    foreach (directed_rows[i]) begin
      transfer_byte(directed_rows[i].rx);
      if (predict_frame_step(directed_rows[i].rx, r) &&
          directed_rows[i].kind == ROW_MODEL)
        expected_results.push_back(r);
      if (directed_rows[i].kind == ROW_BYTE)
        expected_results.push_back('{1'b0, directed_rows[i].data_byte, STAT_OK, '0});
      if (directed_rows[i].kind == ROW_STATUS)
        expected_results.push_back('{1'b1, 8'h00, directed_rows[i].frame_status,
                                     directed_rows[i].payload_count});
    end

    // Random frames in five idle phases; every byte sent counts against the phase budget.
    for (int ph = 0; ph < 5; ph++) begin
      in_idle_pct = in_idle_by_phase[ph];
      out_stall_pct = out_stall_by_phase[ph];
      phase_end = items_sent + 100;
      if (ph == 0) begin
        // Stall the receiver and keep offering a long frame back to back: fill the block.
        -> hold_off_start;
        send_frame(60, 1'b0, 1'b0);
      end
      // One frame just past the coded-byte limit: the last byte in range is still
      // decoded, the one after it sets overflow.
      if (ph == 3) send_long_frame(CODED_LIMIT + 1);
      while (items_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 60) send_frame(pick_payload_len(), 1'b0, 1'b0);
        else if (pick < 72) send_frame(pick_payload_len(), 1'b1, 1'b0);
        else if (pick < 82) send_frame(pick_payload_len(), $urandom_range(1), 1'b1);
        else if (pick < 92) send_noise_frame();
        else begin
          // A few stray bytes between frames.
          repeat ($urandom_range(1, 3)) begin
            send_link_byte(8'($urandom));
            items_sent++;
          end
        end
      end
    end

    // Drain: stop offering, let the receiver take everything.
    in_valid <= 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      n_errors++;
      $display("%0t: results missing: expected %0d more, actual 0", $time,
               expected_results.size());
    end

    if (n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
